/* sv/fmms_pkg.sv */
// Shared types, constants and helper functions for the FASTA motif scanner.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fmms_pkg;

    localparam int unsigned PAT_BYTES = 16;
    localparam int unsigned LEN_W     = 5;
    localparam int unsigned CFG_W     = 64;

    localparam logic [7:0] LINE_END    = 8'd10;
    localparam logic [7:0] HEADER_MARK = 8'h3E;

    typedef enum logic [1:0] {
        CFG_LENGTH = 2'd0,
        CFG_LOW    = 2'd1,
        CFG_HIGH   = 2'd2
    } cfg_index_t;

    typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             ok;
        pat_bytes_t       bytes;
    } pat_cfg_t;

    function automatic logic is_amino(input logic [7:0] b);
        logic r;
        unique case (b)
            "D", "E", "R", "K", "H", "N", "Q", "S", "T", "Y",
            "A", "G", "V", "L", "I", "P", "F", "M", "W", "C": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/fmms_pattern.sv */
// Pattern registers of the motif scanner and the check that the pattern is usable.
// Depends on fmms_pkg.
`default_nettype none

module fmms_pattern
    import fmms_pkg::*;
#(
    parameter int unsigned PATTERN_MAX = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    output pat_cfg_t              pat
);

    logic [LEN_W-1:0] len_reg;
    logic [CFG_W-1:0] low_reg;
    logic [CFG_W-1:0] high_reg;
    logic             ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            low_reg  <= '0;
            high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LENGTH: len_reg  <= cfg_data[LEN_W-1:0];
                CFG_LOW:    low_reg  <= cfg_data;
                CFG_HIGH:   high_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        ok = (len_reg != '0) && (32'(len_reg) <= PATTERN_MAX);
        for (int j = 0; j < PAT_BYTES; j++)
        begin
            if ((j < 32'(len_reg)) && !is_amino(pat.bytes[j]))
            begin
                ok = 1'b0;
            end
        end
    end

    assign pat.len   = len_reg;
    assign pat.bytes = pat_bytes_t'({high_reg, low_reg});
    assign pat.ok    = ok;

endmodule

`default_nettype wire

/* sv/fmms_scan.sv */
// Record parser, symbol history and parallel pattern compare with the result register.
// Depends on fmms_pkg.
`default_nettype none

module fmms_scan
    import fmms_pkg::*;
#(
    parameter int unsigned PATTERN_MAX   = 16,
    parameter int unsigned POSITION_BITS = 32,
    parameter int unsigned RECORD_BITS   = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     step,
    input  wire logic [7:0]               byte_in,
    input  wire pat_cfg_t                 pat,
    input  wire logic                     out_ready,
    output logic                          out_valid,
    output logic [RECORD_BITS-1:0]        record_number,
    output logic [POSITION_BITS-1:0]      match_start,
    output logic [POSITION_BITS-1:0]      match_end
);

    localparam int unsigned SINCE_W = $clog2(PATTERN_MAX + 1);
    localparam logic [SINCE_W-1:0] SINCE_MAX = SINCE_W'(PATTERN_MAX);

    logic                          line_start_reg, line_start_next;
    logic                          in_header_reg, in_header_next;
    logic [RECORD_BITS-1:0]        rec_reg, rec_next;
    logic [POSITION_BITS-1:0]      pos_reg, pos_next;
    logic [SINCE_W-1:0]            since_reg, since_next;
    logic [PATTERN_MAX-1:0][7:0]   hist_reg, hist_next;
    logic                          out_valid_reg;
    logic [RECORD_BITS-1:0]        rec_out_reg;
    logic [POSITION_BITS-1:0]      start_reg, start_next;
    logic [POSITION_BITS-1:0]      end_reg;
    logic                          symbol;
    logic                          hit;
    logic [LEN_W-1:0]              pidx;

    always_comb
    begin
        line_start_next = line_start_reg;
        in_header_next  = in_header_reg;
        rec_next        = rec_reg;
        pos_next        = pos_reg;
        since_next      = since_reg;
        hist_next       = hist_reg;
        symbol          = 1'b0;
        pidx            = '0;
        priority if (byte_in == LINE_END)
        begin
            line_start_next = 1'b1;
            in_header_next  = 1'b0;
        end
        else if (line_start_reg && (byte_in == HEADER_MARK))
        begin
            line_start_next = 1'b0;
            in_header_next  = 1'b1;
            if (rec_reg != '1)
            begin
                rec_next = rec_reg + 1'b1;
            end
            pos_next   = '0;
            since_next = '0;
        end
        else
        begin
            line_start_next = 1'b0;
            if (!in_header_reg && (rec_reg != '0))
            begin
                symbol = 1'b1;
                for (int k = PATTERN_MAX - 1; k > 0; k--)
                begin
                    hist_next[k] = hist_reg[k-1];
                end
                hist_next[0] = byte_in;
                if (pos_reg != '1)
                begin
                    pos_next = pos_reg + 1'b1;
                end
                if (since_reg < SINCE_MAX)
                begin
                    since_next = since_reg + 1'b1;
                end
            end
        end

        // Newest symbol sits at index 0 and meets the last pattern byte.
        hit = symbol && pat.ok && (6'(since_next) >= 6'(pat.len));
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            pidx = pat.len - LEN_W'(k) - 1'b1;
            if ((k < 32'(pat.len)) && (hist_next[k] != pat.bytes[pidx[3:0]]))
            begin
                hit = 1'b0;
            end
        end
        if (hit)
        begin
            since_next = '0;
        end
        start_next = pos_next - POSITION_BITS'(pat.len) + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_start_reg <= 1'b1;
            in_header_reg  <= 1'b0;
            rec_reg        <= '0;
            pos_reg        <= '0;
            since_reg      <= '0;
            hist_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                line_start_reg <= line_start_next;
                in_header_reg  <= in_header_next;
                rec_reg        <= rec_next;
                pos_reg        <= pos_next;
                since_reg      <= since_next;
                hist_reg       <= hist_next;
                out_valid_reg  <= hit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && hit)
        begin
            rec_out_reg <= rec_reg == '0 ? rec_next : rec_reg;
            start_reg   <= start_next;
            end_reg     <= pos_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign record_number = rec_out_reg;
    assign match_start   = start_reg;
    assign match_end     = end_reg;

endmodule

`default_nettype wire

/* sv/fasta_motif_match_scanner.sv */
// Top level of the FASTA motif scanner: input register, pattern registers and scan core.
// Depends on fmms_pkg, fmms_pattern and fmms_scan.
//
// The block takes FASTA text one byte per request on the in channel (in_valid, in_ready,
// data_byte) and reports each non-overlapping match of the configured pattern as one
// request on the out channel (record_number, match_start, match_end).
// The pattern is written through cfg_we, cfg_index and cfg_data while the block is idle:
// index 0 is the length, index 1 bytes 0 to 7, index 2 bytes 8 to 15.
// Keeping the writes to idle is up to the user; the block does not enforce it. A byte
// accepted on the in channel is held in the input register, then processed when the scan
// core steps; its result, if any, is presented from the result register. One byte is
// accepted in every cycle unless the receiver stalls; the combinational compare of the
// history window against the pattern allows that rate.
// When the receiver stalls, the result register holds its request and one more byte
// waits in the input register; in_ready then falls until the result is taken.
// Reset clears the parser, the history, the counts, the pattern and both valid flags.
`default_nettype none

module fasta_motif_match_scanner
    import fmms_pkg::*;
#(
    parameter int unsigned PATTERN_MAX   = 16,
    parameter int unsigned POSITION_BITS = 32,
    parameter int unsigned RECORD_BITS   = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [7:0]               data_byte,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [RECORD_BITS-1:0]        record_number,
    output logic [POSITION_BITS-1:0]      match_start,
    output logic [POSITION_BITS-1:0]      match_end,
    input  wire logic                     cfg_we,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data
);

    logic       in_full_reg;
    logic [7:0] in_byte_reg;
    logic       step;
    pat_cfg_t   pat;

    assign step     = in_full_reg && (!out_valid || out_ready);
    assign in_ready = !in_full_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
        end
    end

    fmms_pattern #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_pattern (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pat       (pat)
    );

    fmms_scan #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS),
        .RECORD_BITS   (RECORD_BITS)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .byte_in       (in_byte_reg),
        .pat           (pat),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .record_number (record_number),
        .match_start   (match_start),
        .match_end     (match_end)
    );

endmodule

`default_nettype wire

/* sim/fasta_motif_match_scanner_test.sv */
// Self-checking testbench for fasta_motif_match_scanner: FASTA text in, motif matches out.
// Depends on fmms_pkg and the RTL of the block; a scoreboard class predicts every match.
`timescale 1ns / 100ps

module fasta_motif_match_scanner_test
    import fmms_pkg::*;
();

    typedef struct {
        logic [15:0] rec;
        logic [31:0] first;
        logic [31:0] last;
    } match_t;

    class match_scoreboard;
        match_t      expected_matches[$];
        int          errors;
        logic [4:0]  pat_len;
        logic [63:0] pat_lo;
        logic [63:0] pat_hi;
        bit          at_line_start;
        bit          in_title;
        logic [15:0] rec_count;
        logic [31:0] sym_pos;
        logic [7:0]  window [16];
        logic [4:0]  run_len;

        function new();
            errors = 0;
            pat_len = '0;
            pat_lo = '0;
            pat_hi = '0;
            at_line_start = 1'b1;
            in_title = 1'b0;
            rec_count = '0;
            sym_pos = '0;
            run_len = '0;
            foreach (window[k])
                window[k] = '0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [63:0] value);
            case (idx)
                CFG_LENGTH: pat_len = value[4:0];
                CFG_LOW:    pat_lo = value;
                CFG_HIGH:   pat_hi = value;
                default:    ;
            endcase
        endfunction

        function logic [7:0] motif_byte(int i);
            if (i < 8)
                return pat_lo[8*i +: 8];
            return pat_hi[8*(i-8) +: 8];
        endfunction

        function bit motif_enabled();
            string residues = "DERKHNQSTYAGVLIPFMWC";
            bit    found;
            if (pat_len == 0 || pat_len > 16)
                return 1'b0;
            for (int i = 0; i < int'(pat_len); i++)
            begin
                found = 1'b0;
                for (int j = 0; j < 20; j++)
                    if (motif_byte(i) == residues[j])
                        found = 1'b1;
                if (!found)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_byte(logic [7:0] b);
            int     len;
            bit     hit;
            match_t m;
            if (b == LINE_END)
            begin
                at_line_start = 1'b1;
                in_title = 1'b0;
                return;
            end
            if (at_line_start && b == HEADER_MARK)
            begin
                at_line_start = 1'b0;
                in_title = 1'b1;
                if (rec_count != 16'hFFFF)
                    rec_count++;
                sym_pos = '0;
                run_len = '0;
                return;
            end
            at_line_start = 1'b0;
            if (in_title || rec_count == 0)
                return;
            for (int k = 15; k > 0; k--)
                window[k] = window[k-1];
            window[0] = b;
            if (sym_pos != 32'hFFFF_FFFF)
                sym_pos++;
            if (run_len < 16)
                run_len++;
            if (!motif_enabled())
                return;
            len = int'(pat_len);
            if (int'(run_len) < len)
                return;
            hit = 1'b1;
            for (int k = 0; k < len; k++)
                if (window[k] != motif_byte(len - 1 - k))
                    hit = 1'b0;
            if (!hit)
                return;
            run_len = '0;
            m.rec = rec_count;
            m.first = sym_pos - 32'(len) + 32'd1;
            m.last = sym_pos;
            expected_matches = {expected_matches, m};
        endfunction

        function void check_match(logic [15:0] rec, logic [31:0] first, logic [31:0] last);
            match_t m;
            if (expected_matches.size() == 0)
            begin
                $error("unexpected match: record %0d, positions %0d to %0d", rec, first, last);
                errors++;
                return;
            end
            m = expected_matches.pop_front();
            if (m.rec !== rec)
            begin
                $error("record_number: expected %0d, got %0d", m.rec, rec);
                errors++;
            end
            if (m.first !== first)
            begin
                $error("match_start: expected %0d, got %0d", m.first, first);
                errors++;
            end
            if (m.last !== last)
            begin
                $error("match_end: expected %0d, got %0d", m.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  data_byte = '0;
    logic        out_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_LENGTH;
    logic [63:0] cfg_data = '0;
    wire         in_ready;
    wire         out_valid;
    wire [15:0]  record_number;
    wire [31:0]  match_start;
    wire [31:0]  match_end;

    match_scoreboard sb;
    string       residues = "DERKHNQSTYAGVLIPFMWC";
    logic [7:0]  motif [16];
    int          motif_len = 0;
    int          burst_left = 0;
    bit          valid_high = 1'b0;
    int          sent_total = 0;
    bit          rx_seg_ready = 1'b0;
    int          rx_left = 0;

    fasta_motif_match_scanner u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .record_number (record_number),
        .match_start   (match_start),
        .match_end     (match_end),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_match(record_number, match_start, match_end);
        if (rx_left == 0)
        begin
            rx_seg_ready = !rx_seg_ready;
            rx_left = rx_seg_ready ? $urandom_range(1, 40) : $urandom_range(1, 10);
            if (rx_seg_ready && $urandom_range(0, 9) == 0)
                rx_left = 300;
        end
        rx_left--;
        out_ready <= rx_seg_ready;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0 && valid_high)
            begin
                in_valid <= 1'b0;
                valid_high = 1'b0;
            end
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 48);
        end
        in_valid <= 1'b1;
        valid_high = 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(b);
        burst_left--;
        sent_total++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic settle();
        if (valid_high)
        begin
            in_valid <= 1'b0;
            valid_high = 1'b0;
        end
        burst_left = 0;
        while (sb.expected_matches.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic load_motif();
        logic [63:0] len_word;
        logic [63:0] lo;
        logic [63:0] hi;
        len_word = {$urandom(), $urandom()};
        len_word[4:0] = 5'(motif_len);
        for (int i = 0; i < 8; i++)
        begin
            lo[8*i +: 8] = motif[i];
            hi[8*i +: 8] = motif[i+8];
        end
        cfg_we <= 1'b1;
        cfg_index <= CFG_LENGTH;
        cfg_data <= len_word;
        sb.write_reg(CFG_LENGTH, len_word);
        @(posedge clk);
        cfg_index <= CFG_LOW;
        cfg_data <= lo;
        sb.write_reg(CFG_LOW, lo);
        @(posedge clk);
        cfg_index <= CFG_HIGH;
        cfg_data <= hi;
        sb.write_reg(CFG_HIGH, hi);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int motif_span();
        return (motif_len >= 1 && motif_len <= 16) ? motif_len : 16;
    endfunction

    function automatic logic [7:0] random_symbol();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return motif[$urandom_range(0, motif_span() - 1)];
        if (r < 93)
            return residues[$urandom_range(0, 19)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic pick_setting(input int phase);
        int          r;
        logic [7:0]  letter_a;
        logic [7:0]  letter_b;
        letter_a = residues[$urandom_range(0, 19)];
        letter_b = residues[$urandom_range(0, 19)];
        r = $urandom_range(0, 9);
        for (int i = 0; i < 16; i++)
            motif[i] = ($urandom_range(0, 1) == 0) ? residues[$urandom_range(0, 19)]
                                                    : 8'($urandom_range(0, 255));
        case (phase)
            0: motif_len = 16;
            1: motif_len = 0;
            2: motif_len = 31;
            3: motif_len = $urandom_range(2, 8);
            4: motif_len = 1;
            5: motif_len = 17;
            6: motif_len = 0;
            default: motif_len = (r == 0) ? 0 : (r == 1) ? $urandom_range(17, 31) :
                                 (r < 7) ? $urandom_range(1, 4) : $urandom_range(5, 16);
        endcase
        for (int i = 0; i < motif_span(); i++)
            motif[i] = (phase > 6 && r >= 5) ? (($urandom_range(0, 1) == 0) ? letter_a : letter_b)
                                             : residues[$urandom_range(0, 19)];
        if (phase == 1)
            foreach (motif[i])
                motif[i] = 8'hFF;
        if (phase == 6)
            foreach (motif[i])
                motif[i] = 8'h00;
        if (phase == 3 || (phase > 6 && r == 2))
        begin
            if (motif_len == 0 || motif_len > 16)
                motif_len = $urandom_range(1, 16);
            motif[$urandom_range(0, motif_len - 1)] = 8'($urandom_range(0, 64));
        end
    endtask

    task automatic emit_record();
        int         n;
        logic [7:0] b;
        send_byte(HEADER_MARK);
        n = $urandom_range(0, 6);
        repeat (n)
        begin
            b = 8'($urandom_range(0, 255));
            send_byte((b == LINE_END) ? 8'h78 : b);
        end
        send_byte(LINE_END);
        n = $urandom_range(0, 3);
        repeat (n)
        begin
            repeat ($urandom_range(0, 24))
            begin
                if ($urandom_range(0, 5) == 0)
                    for (int i = 0; i < motif_span(); i++)
                        send_byte(motif[i]);
                else
                    send_byte(random_symbol());
            end
            send_byte(LINE_END);
        end
    endtask

    initial
    begin : stimulus
        int phase_base;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (motif[i])
            motif[i] = "A";
        motif_len = 2;
        load_motif();
        send_str("AA\n");
        send_byte(HEADER_MARK);
        send_byte(8'hFF);
        send_byte(LINE_END);
        send_str("AAAAA\n\nA");
        send_byte(8'h00);
        send_str(">AA\n>\nA\n>\nA\n");

        for (int phase = 0; phase < 12; phase++)
        begin
            settle();
            pick_setting(phase);
            load_motif();
            phase_base = sent_total;
            while (sent_total - phase_base < 170)
                emit_record();
        end

        settle();
        foreach (motif[i])
            motif[i] = "W";
        motif_len = 1;
        load_motif();
        send_str("WW\n>\nW\n");

        settle();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #(64'd60_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* sim.f */
sv/fmms_pkg.sv
sv/fmms_pattern.sv
sv/fmms_scan.sv
sv/fasta_motif_match_scanner.sv
sim/fasta_motif_match_scanner_test.sv
